/* hw/rtl/ftbp_pkg.sv */
// Shared types, character constants and the base-code function for the FASTA packer.
package ftbp_pkg;

   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 30;
   localparam int TOTAL_W  = 32;
   localparam int WINDOW_W = 14;
   localparam int SLOT_W   = 3;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_HEADER  = 8'h3E;
   localparam logic [CHAR_W-1:0] CHAR_UC_C    = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_UC_G    = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_UC_T    = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_LC_C    = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_LC_G    = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_LC_T    = 8'h74;

   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   typedef struct packed {
      logic [1:0]         phase;
      logic [7:0]         packed_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               is_length;
      logic [TOTAL_W-1:0] total_bases;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic emit;
   } flush_stat_type;

   function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] c);
      logic [1:0] code;
      code = CODE_A;
      if (c inside {CHAR_UC_C, CHAR_LC_C}) code = CODE_C;
      if (c inside {CHAR_UC_G, CHAR_LC_G}) code = CODE_G;
      if (c inside {CHAR_UC_T, CHAR_LC_T}) code = CODE_T;
      return code;
   endfunction

endpackage

/* hw/rtl/ftbp_parse.sv */
// Line parser: header skipping, base window, base counter and per-base byte output.
module ftbp_parse
   import ftbp_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [CHAR_W-1:0]     char_in,
   input  logic                  end_of_text,
   output logic                  item_valid,
   output rsp_type               item,
   output logic [COUNT_BITS-1:0] snap_count,
   output logic [WINDOW_W-1:0]   snap_window
);

   localparam int KW      = COUNT_BITS - 2;
   localparam int IDX_EXT = (KW > INDEX_W) ? KW : INDEX_W;

   logic                  hdr_ff, hdr_in;
   logic                  lstart_ff, lstart_in;
   logic [WINDOW_W-1:0]   window_ff, window_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  hdr_now;
   logic [WINDOW_W-1:0]   shifted;
   logic [COUNT_BITS-1:0] count_inc;
   logic [KW-1:0]         kq;
   logic [IDX_EXT-1:0]    idx_ext;

   assign hdr_now   = hdr_ff | (lstart_ff & (char_in == CHAR_HEADER));
   assign shifted   = {window_ff[WINDOW_W-3:0], base_code(char_in)};
   assign count_inc = count_ff + COUNT_BITS'(1);
   assign kq        = count_inc[COUNT_BITS-1:2] - KW'(1);
   assign idx_ext   = IDX_EXT'(kq);

   assign snap_count  = count_ff;
   assign snap_window = window_ff;

   always_comb begin
      hdr_in     = hdr_ff;
      lstart_in  = lstart_ff;
      window_in  = window_ff;
      count_in   = count_ff;
      item_valid = 1'b0;
      if (take) begin
         if (end_of_text) begin
            hdr_in    = 1'b0;
            lstart_in = 1'b1;
            window_in = '0;
            count_in  = '0;
         end else if (char_in == CHAR_NEWLINE) begin
            hdr_in    = 1'b0;
            lstart_in = 1'b1;
         end else begin
            lstart_in = 1'b0;
            hdr_in    = hdr_now;
            if (!hdr_now) begin
               window_in = shifted;
               // A saturated counter still shifts bases in but emits nothing.
               if (!(&count_ff)) begin
                  count_in   = count_inc;
                  item_valid = |count_inc[COUNT_BITS-1:2];
               end
            end
         end
      end
   end

   always_comb begin
      item.phase       = count_inc[1:0];
      item.packed_byte = shifted[7:0];
      item.byte_index  = idx_ext[INDEX_W-1:0];
      item.is_length   = 1'b0;
      item.total_bases = '0;
      item.last        = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff    <= 1'b0;
         lstart_ff <= 1'b1;
         window_ff <= '0;
         count_ff  <= '0;
      end else begin
         hdr_ff    <= hdr_in;
         lstart_ff <= lstart_in;
         window_ff <= window_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/ftbp_flush.sv */
// End-of-text flush sequencer: walks eight phase slots and emits the padded tail bytes.
module ftbp_flush
   import ftbp_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] snap_count,
   input  logic [WINDOW_W-1:0]   snap_window,
   input  logic                  out_free,
   output flush_stat_type        stat,
   output rsp_type               item
);

   localparam int KW      = COUNT_BITS - 2;
   localparam int IDX_EXT = (KW > INDEX_W) ? KW : INDEX_W;
   localparam int TOT_EXT = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

   logic                  busy_ff, busy_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [WINDOW_W-1:0]   win_ff, win_in;

   logic [1:0]         r;
   logic [KW-1:0]      k;
   logic               kz;
   logic [1:0]         cnt [4];
   logic [1:0]         last_p;
   logic               last_j;
   logic [1:0]         cur_p;
   logic               cur_j;
   logic               slot_ok;
   logic               is_last;
   logic               use_k;
   logic [KW-1:0]      k_adj;
   logic [KW-1:0]      idx_full;
   logic [IDX_EXT-1:0] idx_ext;
   logic [TOT_EXT-1:0] tot_ext;
   logic [4:0]         base;
   logic [4:0]         span [4];
   logic [1:0]         code [4];

   assign r     = n_ff[1:0];
   assign k     = n_ff[COUNT_BITS-1:2];
   assign kz    = (k == '0);
   assign cur_p = slot_ff[2:1];
   assign cur_j = slot_ff[0];

   // Bytes left per phase: zero, one or two, plus a lone length beat for an empty stream.
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         if (kz && (r == 2'd0))      cnt[p] = (p == 0) ? 2'd1 : 2'd0;
         else if (r == 2'd0)         cnt[p] = (p == 0) ? 2'd0 : 2'd1;
         else if (2'(p) <= r)        cnt[p] = 2'd1;
         else                        cnt[p] = kz ? 2'd1 : 2'd2;
      end
   end

   always_comb begin
      last_p = 2'd0;
      for (int p = 0; p < 4; p++) begin
         if (cnt[p] != 2'd0) last_p = 2'(p);
      end
      last_j = cnt[last_p][1];
   end

   assign slot_ok = {1'b0, cur_j} < cnt[cur_p];
   assign is_last = (cur_p == last_p) && (cur_j == last_j);

   // The first unflushed byte of a phase starts one word back when the phase lags the remainder.
   assign use_k    = (r >= cur_p) || kz;
   assign k_adj    = use_k ? k : (k - KW'(1));
   assign idx_full = k_adj + KW'(cur_j);
   assign idx_ext  = IDX_EXT'(idx_full);
   assign tot_ext  = TOT_EXT'(n_ff);

   // Distance from the newest base, in the window; negative means past the end.
   assign base = use_k ? (5'(r) - 5'(cur_p) - 5'd1) : (5'(r) + 5'd3 - 5'(cur_p));

   always_comb begin
      for (int q = 0; q < 4; q++) begin
         span[q] = base - {2'b00, cur_j, 2'b00} - 5'(q);
         if (!span[q][4] && (span[q][3:0] <= 4'd6)) begin
            code[q] = win_ff[{span[q][2:0], 1'b0} +: 2];
         end else begin
            code[q] = CODE_A;
         end
      end
   end

   always_comb begin
      item.phase       = cur_p;
      item.packed_byte = {code[0], code[1], code[2], code[3]};
      item.byte_index  = idx_ext[INDEX_W-1:0];
      item.is_length   = is_last;
      item.total_bases = is_last ? tot_ext[TOTAL_W-1:0] : '0;
      item.last        = is_last;
   end

   assign stat.busy = busy_ff;
   assign stat.emit = busy_ff & slot_ok & out_free;

   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      n_in    = n_ff;
      win_in  = win_ff;
      if (start) begin
         busy_in = 1'b1;
         slot_in = '0;
         n_in    = snap_count;
         win_in  = snap_window;
      end else if (busy_ff) begin
         if (!slot_ok) begin
            slot_in = slot_ff + SLOT_W'(1);
         end else if (out_free) begin
            if (is_last) busy_in = 1'b0;
            else         slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      win_ff <= win_in;
   end

endmodule

/* hw/rtl/fasta_two_bit_packer.sv */
// FASTA text to 2-bit packed bases, four phase streams: input stage, parser, flush, output stage.
//
// Usage: text enters on the req_ channel, one character per beat in req_tdata; a beat with
// req_tlast set ends the text, and its character is ignored. Header lines and newlines are
// dropped; every other character is a base. Once four or more bases have arrived, every base
// produces one packed byte beat on the rsp_ channel for the phase stream it completes.
// An accepted character is registered in the input stage, then in the output stage as its result
// beat; with rsp_tready held high and no flush running the block takes one character every cycle.
// An end-of-text beat starts the flush sequencer, which steps through eight phase slots, one per
// cycle while no beat stalls, and sends between one and six beats; the final one carries
// rsp_tuser (length) and rsp_tlast with the base count. When the receiver stalls, the output
// register holds its beat and the input stage fills; req_tready falls when a full input stage
// is held by a stall or by the flush. Synchronous reset clears the parser state (not in a header,
// at line start, empty window, zero count) and empties both stages.
module fasta_two_bit_packer
   import ftbp_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [1:0] phase, [9:2] packed_byte, [39:10] byte_index,
                                    // [71:40] total_bases
   output logic        rsp_tuser,   // is_length
   output logic        rsp_tlast    // last
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff, in_char_in;
   logic              in_eot_ff, in_eot_in;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic                  out_free;
   logic                  take;
   logic                  base_valid;
   rsp_type               base_item;
   rsp_type               flush_item;
   flush_stat_type        flush_stat;
   logic [COUNT_BITS-1:0] snap_count;
   logic [WINDOW_W-1:0]   snap_window;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign take       = in_valid_ff && out_free && !flush_stat.busy;
   assign req_tready = !in_valid_ff || take;

   ftbp_parse #(.COUNT_BITS(COUNT_BITS)) u_parse (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_in     (in_char_ff),
      .end_of_text (in_eot_ff),
      .item_valid  (base_valid),
      .item        (base_item),
      .snap_count  (snap_count),
      .snap_window (snap_window)
   );

   ftbp_flush #(.COUNT_BITS(COUNT_BITS)) u_flush (
      .clock       (clock),
      .reset       (reset),
      .start       (take && in_eot_ff),
      .snap_count  (snap_count),
      .snap_window (snap_window),
      .out_free    (out_free),
      .stat        (flush_stat),
      .item        (flush_item)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_eot_in   = in_eot_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
         in_eot_in   = req_tlast;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (flush_stat.emit) begin
         out_valid_in = 1'b1;
         out_data_in  = flush_item;
      end else if (take && base_valid) begin
         out_valid_in = 1'b1;
         out_data_in  = base_item;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      in_eot_ff   <= in_eot_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff.total_bases, out_data_ff.byte_index,
                        out_data_ff.packed_byte, out_data_ff.phase};
   assign rsp_tuser  = out_data_ff.is_length;
   assign rsp_tlast  = out_data_ff.last;

endmodule

/* hw/rtl/ftbp_checker.sv */
// Port-level checks on the result channel of the FASTA packer, bound to the top level.
module ftbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // The length report always rides on the final beat of a flush, never elsewhere.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("length flag and last flag disagree");

   // Beats that are not the length report carry a zero count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[71:40] == 32'd0))
      else $error("count present on a plain byte beat");

   // A stalled beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                        && $stable(rsp_tlast)))
      else $error("stalled result beat changed");

   // Reset leaves the result channel empty.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind fasta_two_bit_packer ftbp_checker u_ftbp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
